// ===== rtl/dftfi_pkg.sv =====
// ----------------------------------------------------------------------------
// dftfi_pkg
// Shared types, constants and twiddle table for the direct DFT block.
// ----------------------------------------------------------------------------
package dftfi_pkg;

	// Fixed widths of the result fields.
	localparam int OUT_W = 24;
	localparam int IDX_W = 6;

	// The twiddle circle always has 64 points; the quarter table is Q1.15.
	localparam int ROM_LOG2 = 6;
	localparam int QCOS_W   = 16;

	typedef logic [ROM_LOG2-1:0] phase_t;

	localparam phase_t QUARTER    = phase_t'(16);
	localparam phase_t HALF       = phase_t'(32);
	localparam phase_t SIN_OFFSET = phase_t'(48);

	// cos over one quarter circle, cos(0) held as 32767.
	localparam logic [QCOS_W-1:0] QCOS [17] = '{
		16'd32767, 16'd32610, 16'd32138, 16'd31357, 16'd30274, 16'd28899,
		16'd27246, 16'd25330, 16'd23170, 16'd20788, 16'd18205, 16'd15447,
		16'd12540, 16'd9512,  16'd6393,  16'd3212,  16'd0
	};

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOG2_LENGTH  = 1'b1;
	localparam logic [2:0]           LOG2_LENGTH_RST  = 3'd6;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// Control tag that travels alongside each term through the MAC pipeline.
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic             end_bin;
		logic [IDX_W-1:0] bin_index;
	} mac_tag_t;

	// Quadrant decode: which quarter-table entry and whether to negate.
	typedef struct packed {
		logic       neg;
		logic [4:0] idx;
	} tw_sel_t;

	function automatic tw_sel_t tw_decode(input phase_t m);
		tw_sel_t r;
		begin
			if (m <= QUARTER) begin
				r.neg = 1'b0;
				r.idx = 5'(m);
			end else if (m <= HALF) begin
				r.neg = 1'b1;
				r.idx = 5'(HALF - m);
			end else if (m <= phase_t'(HALF + QUARTER)) begin
				r.neg = 1'b1;
				r.idx = 5'(m - HALF);
			end else begin
				r.neg = 1'b0;
				r.idx = 5'(phase_t'(0) - m);
			end
			return r;
		end
	endfunction

endpackage

// ===== rtl/dftfi_ram.sv =====
// ----------------------------------------------------------------------------
// dftfi_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module dftfi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/dftfi_twiddle.sv =====
// ----------------------------------------------------------------------------
// dftfi_twiddle
// Twiddle lookup: cos and sin of a 64-point circle from the quarter table,
// scaled to the twiddle width, registered.
// ----------------------------------------------------------------------------
module dftfi_twiddle #(
	parameter int TWIDDLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           en,
	input  dftfi_pkg::phase_t              phase,
	output logic signed [TWIDDLE_BITS-1:0] cos_s1,
	output logic signed [TWIDDLE_BITS-1:0] sin_s1
);

	dftfi_pkg::tw_sel_t                sel_c;
	dftfi_pkg::tw_sel_t                sel_s;
	logic [dftfi_pkg::QCOS_W-1:0]      mag_c;
	logic [dftfi_pkg::QCOS_W-1:0]      mag_s;
	logic [TWIDDLE_BITS-1:0]           sc_c;
	logic [TWIDDLE_BITS-1:0]           sc_s;
	logic signed [TWIDDLE_BITS-1:0]    cos_d;
	logic signed [TWIDDLE_BITS-1:0]    sin_d;

	assign sel_c = dftfi_pkg::tw_decode(phase);
	assign sel_s = dftfi_pkg::tw_decode(dftfi_pkg::phase_t'(phase + dftfi_pkg::SIN_OFFSET));
	assign mag_c = dftfi_pkg::QCOS[sel_c.idx];
	assign mag_s = dftfi_pkg::QCOS[sel_s.idx];

	// The magnitude is scaled before the sign is applied.
	generate
		if (TWIDDLE_BITS <= dftfi_pkg::QCOS_W) begin : g_narrow
			assign sc_c = TWIDDLE_BITS'(mag_c >> (dftfi_pkg::QCOS_W - TWIDDLE_BITS));
			assign sc_s = TWIDDLE_BITS'(mag_s >> (dftfi_pkg::QCOS_W - TWIDDLE_BITS));
		end else begin : g_wide
			assign sc_c = TWIDDLE_BITS'(mag_c) << (TWIDDLE_BITS - dftfi_pkg::QCOS_W);
			assign sc_s = TWIDDLE_BITS'(mag_s) << (TWIDDLE_BITS - dftfi_pkg::QCOS_W);
		end
	endgenerate

	assign cos_d = sel_c.neg ? -$signed(sc_c) : $signed(sc_c);
	assign sin_d = sel_s.neg ? -$signed(sc_s) : $signed(sc_s);

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s1 <= cos_d;
			sin_s1 <= sin_d;
		end
	end

endmodule

// ===== rtl/dftfi_cmac.sv =====
// ----------------------------------------------------------------------------
// dftfi_cmac
// Shared complex multiply-accumulate unit: four products registered, then
// one accumulate stage per real and imaginary part.
// ----------------------------------------------------------------------------
module dftfi_cmac #(
	parameter int SAMPLE_BITS  = 16,
	parameter int TWIDDLE_BITS = 16,
	parameter int ACC_W        = 39
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           inverse,
	input  logic signed [SAMPLE_BITS-1:0]  xr,
	input  logic signed [SAMPLE_BITS-1:0]  xi,
	input  logic signed [TWIDDLE_BITS-1:0] cos_v,
	input  logic signed [TWIDDLE_BITS-1:0] sin_v,
	input  dftfi_pkg::mac_tag_t            tag_in,
	output logic signed [ACC_W-1:0]        acc_re_s3,
	output logic signed [ACC_W-1:0]        acc_im_s3,
	output dftfi_pkg::mac_tag_t            tag_s3
);

	localparam int PW = SAMPLE_BITS + TWIDDLE_BITS;

	logic signed [PW-1:0]    p_rc_s2;
	logic signed [PW-1:0]    p_is_s2;
	logic signed [PW-1:0]    p_ic_s2;
	logic signed [PW-1:0]    p_rs_s2;
	dftfi_pkg::mac_tag_t     tag_s2;
	logic signed [ACC_W-1:0] term_re;
	logic signed [ACC_W-1:0] term_im;

	always_ff @(posedge clk) begin
		if (en) begin
			p_rc_s2 <= PW'(xr) * PW'(cos_v);
			p_is_s2 <= PW'(xi) * PW'(sin_v);
			p_ic_s2 <= PW'(xi) * PW'(cos_v);
			p_rs_s2 <= PW'(xr) * PW'(sin_v);
		end
	end

	// Forward multiplies by the conjugate twiddle, inverse by the twiddle.
	always_comb begin
		if (inverse) begin
			term_re = ACC_W'(p_rc_s2) - ACC_W'(p_is_s2);
			term_im = ACC_W'(p_ic_s2) + ACC_W'(p_rs_s2);
		end else begin
			term_re = ACC_W'(p_rc_s2) + ACC_W'(p_is_s2);
			term_im = ACC_W'(p_ic_s2) - ACC_W'(p_rs_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en && tag_s2.valid) begin
			acc_re_s3 <= (tag_s2.first ? '0 : acc_re_s3) + term_re;
			acc_im_s3 <= (tag_s2.first ? '0 : acc_im_s3) + term_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
		end
	end

endmodule

// ===== rtl/direct_dft_forward_inverse.sv =====
// ----------------------------------------------------------------------------
// direct_dft_forward_inverse
// Direct O(N^2) complex DFT, forward or inverse, on Q1.15 samples.
// ----------------------------------------------------------------------------
// Samples arrive one per transaction and are written into a sample RAM. The
// transaction that completes a set of N = 2^log2_length samples starts the
// transform, and the block then stalls its input until every term has been
// issued. Each bin is the sum of N complex products computed by a single
// complex multiply-accumulate unit (four multipliers), which takes one term
// per clock while the output is not stalled, so a transform issues
// N*N terms and then drains its pipeline. Loading accepts samples
// back to back. The N results leave in bin order through an output
// register, the last one flagged by last_bin; when the output is
// stalled the whole compute pipeline freezes in place.
// The forward transform uses exp(-2*pi*i*k*n/N); the inverse uses
// exp(+2*pi*i*k*n/N) and shifts right by a further log2_length bits in place
// of the 1/N factor. Sums are kept at full precision and each result is an
// arithmetic right shift (floor) of the sum by 15 (plus log2_length for the
// inverse), then taken to 24 bits. The sample RAM holds 2^L_MAX entries with
// L_MAX = min(6, floor(log2(MAX_POINTS))); it needs no clearing after reset,
// since every entry is written before it is read. log2_length values below 1
// act as 1 and values above L_MAX act as L_MAX. If log2_length is lowered in
// the middle of a load, the next sample starts the transform over entries
// 0 to N-1. Configuration may only be written while no transform is pending.
// ----------------------------------------------------------------------------
module direct_dft_forward_inverse #(
	parameter int MAX_POINTS   = 64,
	parameter int SAMPLE_BITS  = 16,
	parameter int TWIDDLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port
	input  logic                                  cfg_write,
	input  logic [dftfi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dftfi_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Sample channel
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]         sample_re,
	input  logic signed [SAMPLE_BITS-1:0]         sample_im,
	// Result channel
	output logic                                  bin_valid,
	input  logic                                  bin_stall,
	output logic signed [dftfi_pkg::OUT_W-1:0]    bin_re,
	output logic signed [dftfi_pkg::OUT_W-1:0]    bin_im,
	output logic [dftfi_pkg::IDX_W-1:0]           bin_index,
	output logic                                  last_bin
);

	// Largest usable log2 length: bounded by the parameter and by the
	// 64-point twiddle circle.
	localparam int MAXL_RAW = $clog2(MAX_POINTS + 1) - 1;
	localparam int MAXL     = (MAXL_RAW > dftfi_pkg::ROM_LOG2) ? dftfi_pkg::ROM_LOG2 : MAXL_RAW;
	localparam int DEPTH    = 1 << MAXL;
	localparam int CNT_W    = MAXL + 1;
	localparam int ACC_W    = SAMPLE_BITS + TWIDDLE_BITS + MAXL + 1;
	localparam int EXT_W    = ACC_W + dftfi_pkg::OUT_W;
	localparam int SH_W     = $clog2(TWIDDLE_BITS + MAXL);

	// Configuration registers
	logic                          inverse_mode_q;
	logic [2:0]                    log2_length_q;
	logic [2:0]                    l_eff;

	// Sequencer
	dftfi_pkg::state_t             state_q;
	logic [CNT_W-1:0]              load_count_q;
	logic [CNT_W-1:0]              load_count_inc;
	logic [CNT_W-1:0]              n_pts;
	logic [MAXL-1:0]               pts_m1;
	logic [MAXL-1:0]               k_q;
	logic [MAXL-1:0]               n_q;
	dftfi_pkg::phase_t             phase_q;
	dftfi_pkg::phase_t             phase_step;
	logic                          sample_accept;
	logic                          fire;
	logic                          adv;
	logic                          issue;
	dftfi_pkg::mac_tag_t           tag_s1;

	// Datapath
	logic [2*SAMPLE_BITS-1:0]      ram_rdata;
	logic signed [TWIDDLE_BITS-1:0] cos_s1;
	logic signed [TWIDDLE_BITS-1:0] sin_s1;
	logic signed [ACC_W-1:0]       acc_re_s3;
	logic signed [ACC_W-1:0]       acc_im_s3;
	dftfi_pkg::mac_tag_t           tag_s3;
	logic                          done;
	logic [SH_W-1:0]               shift_amt;
	logic signed [EXT_W-1:0]       ext_re;
	logic signed [EXT_W-1:0]       ext_im;

	// Output register
	logic                                 bin_valid_q;
	logic signed [dftfi_pkg::OUT_W-1:0]   bin_re_q;
	logic signed [dftfi_pkg::OUT_W-1:0]   bin_im_q;
	logic [dftfi_pkg::IDX_W-1:0]          bin_index_q;
	logic                                 last_bin_q;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_mode_q <= 1'b0;
			log2_length_q  <= dftfi_pkg::LOG2_LENGTH_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dftfi_pkg::CFG_INVERSE_MODE: inverse_mode_q <= cfg_data[0];
				dftfi_pkg::CFG_LOG2_LENGTH:  log2_length_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the requested length to what the block supports.
	always_comb begin
		priority if (log2_length_q < 3'd1) begin
			l_eff = 3'd1;
		end else if (log2_length_q > 3'(MAXL)) begin
			l_eff = 3'(MAXL);
		end else begin
			l_eff = log2_length_q;
		end
	end

	assign n_pts  = CNT_W'(1) << l_eff;
	assign pts_m1 = MAXL'(n_pts - CNT_W'(1));

	// ------------------------------------------------------------------
	// Load and sequencing
	// ------------------------------------------------------------------
	// The whole compute pipeline moves only when the output register can
	// take a new result.
	assign adv            = !bin_valid_q || !bin_stall;
	assign sample_stall   = (state_q != dftfi_pkg::ST_LOAD);
	assign sample_accept  = sample_valid && !sample_stall;
	assign load_count_inc = load_count_q + CNT_W'(1);
	assign fire           = load_count_inc >= n_pts;
	assign issue          = (state_q == dftfi_pkg::ST_RUN) && adv;

	// Twiddle index for term k of bin n is (k*n mod N) on the 64-point
	// circle, built up by adding n scaled to the circle at every term.
	assign phase_step = dftfi_pkg::phase_t'(n_q) << (3'(dftfi_pkg::ROM_LOG2) - l_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dftfi_pkg::ST_LOAD;
			load_count_q <= '0;
			k_q          <= '0;
			n_q          <= '0;
			phase_q      <= '0;
		end else begin
			unique case (state_q)
				dftfi_pkg::ST_LOAD: begin
					if (sample_accept) begin
						if (fire) begin
							load_count_q <= '0;
							k_q          <= '0;
							n_q          <= '0;
							phase_q      <= '0;
							state_q      <= dftfi_pkg::ST_RUN;
						end else begin
							load_count_q <= load_count_inc;
						end
					end
				end
				dftfi_pkg::ST_RUN: begin
					if (issue) begin
						if (k_q == pts_m1) begin
							k_q     <= '0;
							phase_q <= '0;
							if (n_q == pts_m1) begin
								n_q     <= '0;
								state_q <= dftfi_pkg::ST_LOAD;
							end else begin
								n_q <= n_q + MAXL'(1);
							end
						end else begin
							k_q     <= k_q + MAXL'(1);
							phase_q <= phase_q + phase_step;
						end
					end
				end
				default: state_q <= dftfi_pkg::ST_LOAD;
			endcase
		end
	end

	// Tag for the term issued this cycle; it lines up with the RAM read
	// data and the twiddle registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.valid     <= issue;
			tag_s1.first     <= (k_q == '0);
			tag_s1.last      <= (k_q == pts_m1);
			tag_s1.end_bin   <= (n_q == pts_m1);
			tag_s1.bin_index <= dftfi_pkg::IDX_W'(n_q);
		end
	end

	// ------------------------------------------------------------------
	// Sample store, twiddles and the shared MAC
	// ------------------------------------------------------------------
	dftfi_ram #(
		.WIDTH (2 * SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_sample_ram (
		.clk   (clk),
		.we    (sample_accept),
		.waddr (load_count_q[MAXL-1:0]),
		.wdata ({sample_re, sample_im}),
		.re    (issue),
		.raddr (k_q),
		.rdata (ram_rdata)
	);

	dftfi_twiddle #(
		.TWIDDLE_BITS (TWIDDLE_BITS)
	) u_twiddle (
		.clk    (clk),
		.en     (adv),
		.phase  (phase_q),
		.cos_s1 (cos_s1),
		.sin_s1 (sin_s1)
	);

	dftfi_cmac #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.TWIDDLE_BITS (TWIDDLE_BITS),
		.ACC_W        (ACC_W)
	) u_cmac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.inverse   (inverse_mode_q),
		.xr        ($signed(ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
		.xi        ($signed(ram_rdata[SAMPLE_BITS-1:0])),
		.cos_v     (cos_s1),
		.sin_v     (sin_s1),
		.tag_in    (tag_s1),
		.acc_re_s3 (acc_re_s3),
		.acc_im_s3 (acc_im_s3),
		.tag_s3    (tag_s3)
	);

	// ------------------------------------------------------------------
	// Result scaling and output register
	// ------------------------------------------------------------------
	// The accumulator holds a finished bin once its last term is in.
	assign done      = tag_s3.valid && tag_s3.last;
	assign shift_amt = SH_W'(TWIDDLE_BITS - 1) + (inverse_mode_q ? SH_W'(l_eff) : SH_W'(0));
	assign ext_re    = EXT_W'(acc_re_s3) >>> shift_amt;
	assign ext_im    = EXT_W'(acc_im_s3) >>> shift_amt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= 1'b0;
		end else if (adv) begin
			bin_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && done) begin
			bin_re_q    <= ext_re[dftfi_pkg::OUT_W-1:0];
			bin_im_q    <= ext_im[dftfi_pkg::OUT_W-1:0];
			bin_index_q <= tag_s3.bin_index;
			last_bin_q  <= tag_s3.end_bin;
		end
	end

	assign bin_valid = bin_valid_q;
	assign bin_re    = bin_re_q;
	assign bin_im    = bin_im_q;
	assign bin_index = bin_index_q;
	assign last_bin  = last_bin_q;

endmodule

// ===== rtl/dftfi_checker.sv =====
// ----------------------------------------------------------------------------
// dftfi_checker
// Port-level checks on the result channel of the direct DFT block.
// ----------------------------------------------------------------------------
module dftfi_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               bin_valid,
	input logic                               bin_stall,
	input logic signed [dftfi_pkg::OUT_W-1:0] bin_re,
	input logic signed [dftfi_pkg::OUT_W-1:0] bin_im,
	input logic [dftfi_pkg::IDX_W-1:0]        bin_index,
	input logic                               last_bin
);

	// A stalled result transaction holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid && bin_stall |=> bin_valid && $stable(bin_re) && $stable(bin_im)
			&& $stable(bin_index) && $stable(last_bin))
		else $error("result changed while stalled");

	// A reset seen at a clock edge leaves no result offered at the next one.
	a_reset: assert property (@(posedge clk) !arst_n |=> !bin_valid)
		else $error("result valid during reset");

	// Every transform has at least two bins, so bin 0 is never the last.
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid && (bin_index == '0) |-> !last_bin)
		else $error("bin 0 flagged as last");

	// The next transform needs new samples, so a gap follows the last bin.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid && !bin_stall && last_bin |=> !bin_valid)
		else $error("result offered right after last bin");

endmodule

bind direct_dft_forward_inverse dftfi_checker u_dftfi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.bin_valid (bin_valid),
	.bin_stall (bin_stall),
	.bin_re    (bin_re),
	.bin_im    (bin_im),
	.bin_index (bin_index),
	.last_bin  (last_bin)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the direct DFT block, forward and inverse.
// Samples are fed from a queue and every completed set is transformed by a
// behavioral model in the bench; the bins coming out are compared one by one.
// ----------------------------------------------------------------------------
module tb;

	localparam int OUT_W        = dftfi_pkg::OUT_W;
	localparam int IDX_W        = dftfi_pkg::IDX_W;
	localparam int SAMPLE_W     = 16;
	localparam int SETTLE       = 16;   // pipeline tail plus output register
	localparam int LONG_HOLD    = 400;  // receiver hold-off used for back-pressure
	localparam int RANDOM_ITEMS = 70;
	localparam int MAX_REPORTS  = 100;

	// Idle percentages per idling mode: sender light, sender heavy, none.
	localparam int SEND_IDLE [3]  = '{22, 73, 0};
	localparam int RECV_STALL [3] = '{73, 22, 0};

	// cos over a quarter of the 64-point circle, Q1.15, cos(0) as 32767.
	localparam int COS_QUARTER [17] = '{
		32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
		20788, 18205, 15447, 12540, 9512, 6393, 3212, 0
	};

	typedef struct {
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
	} sample_t;

	typedef struct {
		logic signed [OUT_W-1:0] re;
		logic signed [OUT_W-1:0] im;
		logic [IDX_W-1:0]        idx;
		logic                    last;
	} dft_bin_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                             cfg_write = 1'b0;
	logic [dftfi_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dftfi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic                       sample_valid = 1'b0;
	logic                       sample_stall;
	logic signed [SAMPLE_W-1:0] sample_re = '0;
	logic signed [SAMPLE_W-1:0] sample_im = '0;

	logic                    bin_valid;
	logic                    bin_stall = 1'b0;
	logic signed [OUT_W-1:0] bin_re;
	logic signed [OUT_W-1:0] bin_im;
	logic [IDX_W-1:0]        bin_index;
	logic                    last_bin;

	direct_dft_forward_inverse uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_re    (sample_re),
		.sample_im    (sample_im),
		.bin_valid    (bin_valid),
		.bin_stall    (bin_stall),
		.bin_re       (bin_re),
		.bin_im       (bin_im),
		.bin_index    (bin_index),
		.last_bin     (last_bin)
	);

	always #5 clk = ~clk;

	// Samples waiting to be offered, and bins the model says must come out.
	sample_t  pending [$];
	dft_bin_t bins_due [$];

	int pushed_items = 0;
	int accepted_items = 0;
	int bins_checked = 0;
	int mismatches = 0;
	int idle_mode = 0;
	int hold_requests = 0;

	// Model state: the configuration as last written, the sample store and
	// the count of samples loaded toward the next transform.
	logic                       inverse_q = 1'b0;
	logic [2:0]                 log2_q = dftfi_pkg::LOG2_LENGTH_RST;
	logic signed [SAMPLE_W-1:0] store_re [64];
	logic signed [SAMPLE_W-1:0] store_im [64];
	int                         load_cnt = 0;

	int         fwd_transforms = 0;
	int         inv_transforms = 0;
	logic [6:0] lengths_seen = '0;

	// The register value is clamped to the lengths the block supports.
	function automatic int length_log2(input logic [2:0] l);
		if (l < 3'd1)
			return 1;
		if (l > 3'd6)
			return 6;
		return int'(l);
	endfunction

	function automatic int twiddle_cos(input logic [5:0] m);
		case (m[5:4])
			2'd0:    return COS_QUARTER[m[3:0]];
			2'd1:    return -COS_QUARTER[16 - m[3:0]];
			2'd2:    return -COS_QUARTER[m[3:0]];
			default: return COS_QUARTER[16 - m[3:0]];
		endcase
	endfunction

	// sin(m) is cos taken a quarter circle back.
	function automatic int twiddle_sin(input logic [5:0] m);
		return twiddle_cos(6'(m + 6'd48));
	endfunction

	// Stores one accepted sample; when the set is complete, computes every
	// bin by direct summation and queues the bins in index order.
	function automatic void load_and_transform(input logic signed [SAMPLE_W-1:0] re,
			input logic signed [SAMPLE_W-1:0] im);
		int         l;
		int         n_pts;
		int         shift;
		int         n;
		int         k;
		longint     acc_re;
		longint     acc_im;
		longint     c;
		longint     s;
		longint     xr;
		longint     xi;
		logic [5:0] ph;
		dft_bin_t   b;
		l = length_log2(log2_q);
		n_pts = 1 << l;
		store_re[load_cnt & 63] = re;
		store_im[load_cnt & 63] = im;
		if (load_cnt < 64)
			load_cnt++;
		if (load_cnt < n_pts)
			return;
		load_cnt = 0;
		shift = 15 + (inverse_q ? l : 0);
		for (n = 0; n < n_pts; n++) begin
			acc_re = 0;
			acc_im = 0;
			for (k = 0; k < n_pts; k++) begin
				ph = 6'(((k * n) & (n_pts - 1)) << (6 - l));
				c = twiddle_cos(ph);
				s = twiddle_sin(ph);
				xr = store_re[k];
				xi = store_im[k];
				if (inverse_q) begin
					acc_re += xr * c - xi * s;
					acc_im += xi * c + xr * s;
				end else begin
					acc_re += xr * c + xi * s;
					acc_im += xi * c - xr * s;
				end
			end
			// Arithmetic shift of a signed sum is a floor division.
			b.re = OUT_W'(acc_re >>> shift);
			b.im = OUT_W'(acc_im >>> shift);
			b.idx = IDX_W'(n);
			b.last = (n == n_pts - 1);
			bins_due.push_back(b);
		end
		if (inverse_q)
			inv_transforms++;
		else
			fwd_transforms++;
		lengths_seen[l] = 1'b1;
	endfunction

	task automatic report_mismatch(input string field, input int bin, input longint got,
			input longint want);
		if (mismatches < MAX_REPORTS)
			$display("%0t: mismatch on %s, bin %0d: got %0d, expected %0d",
				$realtime, field, bin, got, want);
		mismatches++;
	endtask

	// Driver: offers queued samples. A sample stays on the port until its
	// transaction completes; only then may the sender take a random idle cycle.
	always @(posedge clk or negedge arst_n) begin : driver
		sample_t nxt;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample_re <= '0;
			sample_im <= '0;
		end else begin
			if (sample_valid && !sample_stall) begin
				load_and_transform(sample_re, sample_im);
				accepted_items++;
			end
			if (!sample_valid || !sample_stall) begin
				if (pending.size() != 0 && $urandom_range(99) >= SEND_IDLE[idle_mode]) begin
					nxt = pending.pop_front();
					sample_valid <= 1'b1;
					sample_re <= nxt.re;
					sample_im <= nxt.im;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall. A hold request from the stimulus starts a long hold-off
	// counted here, so the block fills up and has to stall its own input.
	int hold_left = 0;
	int hold_served = 0;

	always @(posedge clk or negedge arst_n) begin : receiver
		if (!arst_n) begin
			bin_stall <= 1'b0;
			hold_left <= 0;
			hold_served <= 0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= LONG_HOLD;
			bin_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			bin_stall <= 1'b1;
		end else begin
			bin_stall <= ($urandom_range(99) < RECV_STALL[idle_mode]);
		end
	end

	// Monitor: every completed result transaction is checked against the
	// oldest bin the model has queued.
	always @(posedge clk) begin : monitor
		dft_bin_t want;
		if (arst_n && bin_valid && !bin_stall) begin
			if (bins_due.size() == 0) begin
				report_mismatch("unexpected result", bin_index, bin_re, 0);
			end else begin
				want = bins_due.pop_front();
				if (bin_re !== want.re)
					report_mismatch("bin_re", want.idx, bin_re, want.re);
				if (bin_im !== want.im)
					report_mismatch("bin_im", want.idx, bin_im, want.im);
				if (bin_index !== want.idx)
					report_mismatch("bin_index", want.idx, bin_index, want.idx);
				if (last_bin !== want.last)
					report_mismatch("last_bin", want.idx, last_bin, want.last);
				bins_checked++;
			end
		end
	end

	// Writes both registers on consecutive edges with the write enable held
	// high, then mirrors them into the model.
	task automatic program_regs(input logic inv, input logic [2:0] l);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= dftfi_pkg::CFG_INVERSE_MODE;
		cfg_data <= {2'b00, inv};
		@(posedge clk);
		cfg_index <= dftfi_pkg::CFG_LOG2_LENGTH;
		cfg_data <= l;
		@(posedge clk);
		cfg_write <= 1'b0;
		inverse_q = inv;
		log2_q = l;
	endtask

	task automatic push_sample(input int re, input int im);
		sample_t s;
		s.re = SAMPLE_W'(re);
		s.im = SAMPLE_W'(im);
		pending.push_back(s);
		pushed_items++;
	endtask

	// Random component with extra weight on the extremes of the Q1.15 range.
	function automatic int random_component();
		case ($urandom_range(9))
			0:       return -32768;
			1:       return 32767;
			2:       return 0;
			3:       return -1;
			default: return int'($signed(SAMPLE_W'($urandom)));
		endcase
	endfunction

	task automatic push_random(input int count);
		repeat (count)
			push_sample(random_component(), random_component());
	endtask

	// Idle means every sample has been taken and every bin has come out; the
	// extra cycles cover the tail of the pipeline before a register write.
	task automatic wait_idle();
		while (accepted_items != pushed_items || bins_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		int         random_items;
		int         mode;
		int         n;
		int         m;
		int         need;
		logic       inv;
		logic [2:0] l;
		logic [2:0] l2;
		bit         pressure_done;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part. Two-point forward transform on full-scale values of
		// opposite sign.
		program_regs(1'b0, 3'd1);
		push_sample(32767, -32768);
		push_sample(-32768, 32767);
		wait_idle();

		// Four-point forward: all positive full scale, then all negative full
		// scale, which gives the largest bin magnitudes at this length.
		program_regs(1'b0, 3'd2);
		repeat (4) push_sample(32767, 32767);
		repeat (4) push_sample(-32768, -32768);
		wait_idle();

		// Four-point inverse, so the extra scaling shift is exercised.
		program_regs(1'b1, 3'd2);
		push_sample(32767, 0);
		push_sample(0, -32768);
		push_sample(-32768, 32767);
		push_sample(-1, 1);
		wait_idle();

		// A length register of zero behaves as a two-point transform.
		program_regs(1'b1, 3'd0);
		push_sample(-32768, -32768);
		push_sample(32767, 32767);
		wait_idle();

		// Length lowered in the middle of a load: five samples of an eight-point
		// set, then the length drops to four and the next sample fires the
		// transform over the first four store entries.
		program_regs(1'b0, 3'd3);
		push_sample(12345, -321);
		push_sample(-20000, 7);
		push_sample(1, -1);
		push_sample(32767, -32768);
		push_sample(-5, 30000);
		wait_idle();
		program_regs(1'b0, 3'd2);
		push_sample(-32768, 32767);
		wait_idle();

		// Random part. It opens with one full-size set at a register value
		// above the supported range, then mostly small sets; the idling mode
		// moves from a slow receiver to a slow sender and then to none.
		random_items = 0;
		pressure_done = 1'b0;
		program_regs(1'($urandom_range(1)), 3'd7);
		push_random(64);
		random_items += 64;
		wait_idle();

		while (random_items < RANDOM_ITEMS || !pressure_done) begin
			mode = (random_items < 64) ? 0 : (random_items < RANDOM_ITEMS) ? 1 : 2;
			if (mode != idle_mode)
				idle_mode <= mode;
			if (mode == 2 && !pressure_done) begin
				// Back-pressure: the receiver holds off for a long stretch while
				// the sender keeps offering two-point sets back to back.
				pressure_done = 1'b1;
				program_regs(1'($urandom_range(1)), 3'd1);
				hold_requests <= hold_requests + 1;
				push_random(12);
				random_items += 12;
				wait_idle();
			end else begin
				inv = 1'($urandom_range(1));
				l = 3'($urandom_range(3));
				program_regs(inv, l);
				n = 1 << length_log2(l);
				if ($urandom_range(3) == 0) begin
					// Partial load, then a new length (and possibly direction)
					// before the set is finished.
					m = $urandom_range(n - 1, 1);
					push_random(m);
					wait_idle();
					l2 = 3'($urandom_range(3));
					program_regs(1'($urandom_range(1)), l2);
					need = (load_cnt >= (1 << length_log2(l2))) ? 1 :
						(1 << length_log2(l2)) - load_cnt;
					push_random(need);
					random_items += m + need;
				end else begin
					m = n * $urandom_range(2, 1);
					push_random(m);
					random_items += m;
				end
				wait_idle();
			end
		end

		wait_idle();
		$display("Run covered %0d samples and %0d bins: %0d forward and %0d inverse transforms.",
			accepted_items, bins_checked, fwd_transforms, inv_transforms);
		$display("Transform sizes used, one bit per log2 length: %b", lengths_seen);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Guard against a hang: far beyond the slowest legal run.
	initial begin : watchdog
		#2_000_000;
		$display("Timeout with %0d bins still due.", bins_due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
